// ===== src/assert_macros.svh =====
// Shared assertion helpers. Both sample on clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define SPLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication check.
`define SPLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/spls_pkg.sv =====
package spls_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FULL_SCALE = 10000;

  // Fixed field widths.
  localparam int LEVEL_W    = 14;
  localparam int FORCE_W    = 16;
  localparam int IDX_W      = 4;
  localparam int OUT_W      = 15;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ENT_W  = 2 * LEVEL_W;
  localparam int ACC_W  = 2 * LEVEL_W;
  localparam int STEP_W = $clog2(LEVEL_W);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_LOAD,
    OP_MUL_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP
  } arith_op_t;

  typedef struct packed {
    arith_op_t          op;
    logic [LEVEL_W-1:0] opa;
    logic [LEVEL_W-1:0] opb;
  } arith_cmd_t;

endpackage

// ===== src/spls_table.sv =====
module spls_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [spls_pkg::ADDR_W-1:0] waddr,
  input  logic [spls_pkg::ENT_W-1:0]  wdata,
  input  logic [spls_pkg::ADDR_W-1:0] raddr,
  output logic [spls_pkg::ENT_W-1:0]  rdata
);

  // Entry layout: output level in the upper half, input level in the lower half.
  logic [spls_pkg::ENT_W-1:0] mem [spls_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/spls_muldiv.sv =====
`include "assert_macros.svh"

module spls_muldiv (
  input  logic                         clk,
  input  logic                         rst,
  input  spls_pkg::arith_cmd_t         cmd,
  output logic [spls_pkg::LEVEL_W-1:0] quotient
);

  logic [spls_pkg::ACC_W-1:0]   acc;
  logic [spls_pkg::ACC_W-1:0]   prod;
  logic [spls_pkg::LEVEL_W-1:0] rem;
  logic [spls_pkg::LEVEL_W-1:0] divisor;
  logic [spls_pkg::LEVEL_W-1:0] qsh;
  logic [spls_pkg::LEVEL_W:0]   trial;

  assign prod  = spls_pkg::ACC_W'(cmd.opa) * spls_pkg::ACC_W'(cmd.opb);
  assign trial = {rem, qsh[spls_pkg::LEVEL_W-1]};

  // Restoring divide: the upper half of acc is already below the divisor,
  // so one quotient bit per step over the lower half is enough.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      spls_pkg::OP_NONE: begin
      end
      spls_pkg::OP_MUL_LOAD: begin
        acc <= prod;
      end
      spls_pkg::OP_MUL_ADD: begin
        acc <= acc + prod;
      end
      spls_pkg::OP_DIV_INIT: begin
        rem     <= acc[spls_pkg::ACC_W-1:spls_pkg::LEVEL_W];
        qsh     <= acc[spls_pkg::LEVEL_W-1:0];
        divisor <= cmd.opa;
      end
      spls_pkg::OP_DIV_STEP: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= spls_pkg::LEVEL_W'(trial - {1'b0, divisor});
          qsh <= {qsh[spls_pkg::LEVEL_W-2:0], 1'b1};
        end else begin
          rem <= spls_pkg::LEVEL_W'(trial);
          qsh <= {qsh[spls_pkg::LEVEL_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign quotient = qsh;

  `SPLS_ASSERT_IMPL(a_rem_below_divisor, $past(cmd.op) == spls_pkg::OP_DIV_INIT || $past(cmd.op) == spls_pkg::OP_DIV_STEP, rem < divisor, "divider remainder not below divisor")

endmodule

// ===== src/symmetric_piecewise_linear_shaper.sv =====
// Piecewise-linear force shaper with a symmetric transfer curve.
// Input stream (s_axis_*): tuser selects the item kind. tuser = 1 writes one
// breakpoint (slot, input level, output level) and gives no result; tlast on
// such a transfer sets the point count to slot + 1. tuser = 0 shapes the
// signed force in tdata and gives one result on the output stream (m_axis_*):
// the shaped force in tdata and, in tuser, whether a table interval matched.
// Breakpoints go in ascending input order; the first matching interval wins.
// Throughput: one item at a time. A force item with fewer than two points
// passes through; otherwise the intervals are scanned one per cycle from the
// single table read port, then a shared 14x14 multiplier forms the numerator
// as a sum of two products and a restoring divider forms the 14-bit quotient
// one bit per cycle. A miss passes the magnitude through and a flat interval
// gives its output level, both without the multiplier and divider.
// Reset empties the table (point count zero); slot contents stay as they were.
// A result waits in the output register while the receiver stalls; a new item
// may be accepted meanwhile, and its result waits until that register frees.
`include "assert_macros.svh"

module symmetric_piecewise_linear_shaper (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // force_req[15:0], point_index[19:16], point_in[33:20], point_out[47:34]
  input  logic [spls_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // ends_table
  input  logic                            s_axis_tlast,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // shaped_force[14:0], zero[15]
  output logic [spls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // table_used
  output logic                            m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD0,
    S_SCAN,
    S_MUL0,
    S_MUL1,
    S_DINIT,
    S_DIV,
    S_OUT
  } state_t;

  localparam int LW = spls_pkg::LEVEL_W;

  state_t state;

  logic [spls_pkg::CNT_W-1:0]  point_count;
  logic [spls_pkg::ADDR_W-1:0] cur_idx;
  logic [spls_pkg::STEP_W-1:0] step;
  logic [spls_pkg::ENT_W-1:0]  prev_ent;
  logic [spls_pkg::ENT_W-1:0]  hit_ent;
  logic [LW-1:0]               mag;
  logic [LW-1:0]               res_mag;
  logic                        neg;
  logic                        hit;
  logic                        use_q;

  logic                         accept;
  logic                         wr_en;
  logic [spls_pkg::FORCE_W-1:0] force_in;
  logic [spls_pkg::IDX_W-1:0]   idx_in;
  logic [LW-1:0]                pin_in;
  logic [LW-1:0]                pout_in;
  logic [spls_pkg::FORCE_W:0]   abs_in;
  logic [LW-1:0]                mag_in;
  logic [spls_pkg::ADDR_W-1:0]  raddr;
  logic [spls_pkg::ENT_W-1:0]   rdata;
  logic [LW-1:0]                cur_x;
  logic [LW-1:0]                prev_x;
  logic [LW-1:0]                prev_y;
  logic [LW-1:0]                quotient;
  logic [LW-1:0]                fin_mag;
  logic [LW-1:0]                sat_mag;
  logic [spls_pkg::OUT_W-1:0]   signed_res;
  logic                         out_free;
  spls_pkg::arith_cmd_t         cmd;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign force_in = s_axis_tdata[15:0];
  assign idx_in   = s_axis_tdata[19:16];
  assign pin_in   = s_axis_tdata[33:20];
  assign pout_in  = s_axis_tdata[47:34];

  assign wr_en = accept && s_axis_tuser && (int'(idx_in) < spls_pkg::MAX_POINTS);

  // Magnitude with the most negative code handled by the extra bit.
  assign abs_in = force_in[spls_pkg::FORCE_W-1] ?
                  (spls_pkg::FORCE_W+1)'(-$signed({force_in[spls_pkg::FORCE_W-1], force_in})) :
                  {1'b0, force_in};
  assign mag_in = (int'(abs_in) > spls_pkg::FULL_SCALE) ? LW'(spls_pkg::FULL_SCALE)
                                                        : LW'(abs_in);

  assign cur_x  = rdata[LW-1:0];
  assign prev_x = prev_ent[LW-1:0];
  assign prev_y = prev_ent[2*LW-1:LW];

  always_comb begin
    if (state == S_IDLE) begin
      raddr = '0;
    end else begin
      raddr = cur_idx + spls_pkg::ADDR_W'(1);
    end
  end

  spls_table u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (spls_pkg::ADDR_W'(idx_in)),
    .wdata ({pout_in, pin_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    cmd.op  = spls_pkg::OP_NONE;
    cmd.opa = '0;
    cmd.opb = '0;
    unique case (state)
      S_MUL0: begin
        cmd.op  = spls_pkg::OP_MUL_LOAD;
        cmd.opa = prev_y;
        cmd.opb = hit_ent[LW-1:0] - mag;
      end
      S_MUL1: begin
        cmd.op  = spls_pkg::OP_MUL_ADD;
        cmd.opa = hit_ent[2*LW-1:LW];
        cmd.opb = mag - prev_x;
      end
      S_DINIT: begin
        cmd.op  = spls_pkg::OP_DIV_INIT;
        cmd.opa = hit_ent[LW-1:0] - prev_x;
      end
      S_DIV: begin
        cmd.op = spls_pkg::OP_DIV_STEP;
      end
      default: begin
      end
    endcase
  end

  spls_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .quotient (quotient)
  );

  assign fin_mag    = use_q ? quotient : res_mag;
  assign sat_mag    = (int'(fin_mag) > spls_pkg::FULL_SCALE) ? LW'(spls_pkg::FULL_SCALE)
                                                              : fin_mag;
  assign signed_res = neg ? -spls_pkg::OUT_W'(sat_mag) : spls_pkg::OUT_W'(sat_mag);
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop valid after a transfer unless a new result is loaded this cycle.
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              if (wr_en && s_axis_tlast) begin
                point_count <= spls_pkg::CNT_W'(idx_in) + spls_pkg::CNT_W'(1);
              end
            end else begin
              neg     <= force_in[spls_pkg::FORCE_W-1];
              mag     <= mag_in;
              res_mag <= mag_in;
              hit     <= 1'b0;
              use_q   <= 1'b0;
              cur_idx <= '0;
              if (point_count >= spls_pkg::CNT_W'(2)) begin
                state <= S_LOAD0;
              end else begin
                state <= S_OUT;
              end
            end
          end
        end
        S_LOAD0: begin
          prev_ent <= rdata;
          cur_idx  <= spls_pkg::ADDR_W'(1);
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (mag >= prev_x && mag <= cur_x) begin
            hit     <= 1'b1;
            hit_ent <= rdata;
            if (cur_x == prev_x) begin
              res_mag <= prev_y;
              state   <= S_OUT;
            end else begin
              state <= S_MUL0;
            end
          end else if (spls_pkg::CNT_W'(cur_idx) + spls_pkg::CNT_W'(1) == point_count) begin
            // No interval matched: pass the magnitude through.
            state <= S_OUT;
          end else begin
            prev_ent <= rdata;
            cur_idx  <= cur_idx + spls_pkg::ADDR_W'(1);
          end
        end
        S_MUL0: begin
          state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_DINIT;
        end
        S_DINIT: begin
          step  <= spls_pkg::STEP_W'(LW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == '0) begin
            use_q <= 1'b1;
            state <= S_OUT;
          end else begin
            step <= step - spls_pkg::STEP_W'(1);
          end
        end
        S_OUT: begin
          // Hold until the output register is free.
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, signed_res};
            m_axis_tuser  <= hit;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPLS_ASSERT(a_count_in_range, int'(point_count) <= spls_pkg::MAX_POINTS, "point count above table depth")
  `SPLS_ASSERT_IMPL(a_out_saturated, m_axis_tvalid, $signed(m_axis_tdata[spls_pkg::OUT_W-1:0]) <= spls_pkg::FULL_SCALE && $signed(m_axis_tdata[spls_pkg::OUT_W-1:0]) >= -spls_pkg::FULL_SCALE, "result outside full scale")
  `SPLS_ASSERT_IMPL(a_busy_no_ready, state != S_IDLE, !s_axis_tready, "input taken while busy")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEM_TARGET   = 1450;
  localparam int SETTLE_CYCLES = 18 + spls_pkg::MAX_POINTS + 40;
  localparam int LIMIT_CYCLES  = 800_000;
  localparam int REPORT_MAX    = 10;

  localparam logic MODE_APPLY = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic [spls_pkg::OUT_W-1:0] shaped;
    logic                       used;
  } shaped_result_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [spls_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tlast;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [spls_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  // Shadow copy of the breakpoint table
  logic [spls_pkg::LEVEL_W-1:0]    bp_in  [spls_pkg::MAX_POINTS];
  logic [spls_pkg::LEVEL_W-1:0]    bp_out [spls_pkg::MAX_POINTS];
  logic [spls_pkg::MAX_POINTS-1:0] slot_written;
  int                              point_count;

  shaped_result_t pending_shapes[$];
  int             fail_count;
  int             items_sent;
  bit             quiet;

  symmetric_piecewise_linear_shaper uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic shaped_result_t shape_force(input logic [spls_pkg::FORCE_W-1:0] raw);
    shaped_result_t r;
    longint mag, res, x0, x1, y0, y1, dx;
    bit neg, found;
    neg = raw[spls_pkg::FORCE_W-1];
    mag = longint'($signed(raw));
    if (neg) begin
      mag = -mag;
    end
    if (mag > spls_pkg::FULL_SCALE) begin
      mag = spls_pkg::FULL_SCALE;
    end
    res = mag;
    found = 1'b0;
    // First matching interval wins
    for (int i = 0; i + 1 < point_count && !found; i++) begin
      x0 = bp_in[i];
      x1 = bp_in[i+1];
      y0 = bp_out[i];
      y1 = bp_out[i+1];
      if (mag >= x0 && mag <= x1) begin
        found = 1'b1;
        dx = x1 - x0;
        if (dx > 0) begin
          res = (y0 * dx + (mag - x0) * (y1 - y0)) / dx;
        end else begin
          res = y0;
        end
      end
    end
    if (res > spls_pkg::FULL_SCALE) begin
      res = spls_pkg::FULL_SCALE;
    end
    if (neg) begin
      res = -res;
    end
    if (res < -spls_pkg::FULL_SCALE) begin
      res = -spls_pkg::FULL_SCALE;
    end
    r.shaped = res[spls_pkg::OUT_W-1:0];
    r.used   = found;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endfunction

  task automatic send_item(input logic mode, input logic [spls_pkg::FORCE_W-1:0] frc,
                           input logic [spls_pkg::IDX_W-1:0] idx,
                           input logic [spls_pkg::LEVEL_W-1:0] pin,
                           input logic [spls_pkg::LEVEL_W-1:0] pout, input logic ends);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pout, pin, idx, frc};
    s_axis_tlast  <= ends;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // Transfer taken at this edge: update the shadow table or queue a result
    items_sent++;
    if (mode == MODE_WRITE) begin
      bp_in[idx]        = pin;
      bp_out[idx]       = pout;
      slot_written[idx] = 1'b1;
      if (ends) begin
        point_count = int'(idx) + 1;
      end
    end else begin
      pending_shapes.insert(pending_shapes.size(), shape_force(frc));
    end
  endtask

  task automatic write_point(input int idx, input int pin, input int pout, input bit ends);
    logic [spls_pkg::MAX_POINTS-1:0] need;
    need = (spls_pkg::MAX_POINTS'(1) << idx) - spls_pkg::MAX_POINTS'(1);
    // Never let the count cover a slot that holds nothing yet
    if ((slot_written & need) != need) begin
      ends = 1'b0;
    end
    send_item(MODE_WRITE, spls_pkg::FORCE_W'($urandom_range(0, 65535)),
              spls_pkg::IDX_W'(idx), spls_pkg::LEVEL_W'(pin), spls_pkg::LEVEL_W'(pout),
              ends);
  endtask

  task automatic apply_force(input int frc);
    send_item(MODE_APPLY, spls_pkg::FORCE_W'(frc),
              spls_pkg::IDX_W'($urandom_range(0, spls_pkg::MAX_POINTS - 1)),
              spls_pkg::LEVEL_W'($urandom_range(0, 16383)),
              spls_pkg::LEVEL_W'($urandom_range(0, 16383)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_shapes.size() != 0);
  endtask

  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return spls_pkg::FULL_SCALE;
    end
    return $urandom_range(0, spls_pkg::FULL_SCALE);
  endfunction

  function automatic int pick_force();
    int r, mag, slot;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return $urandom_range(0, 65535);
    end else if (r == 1) begin
      case ($urandom_range(0, 4))
        0: return 32767;
        1: return -32768;
        2: return spls_pkg::FULL_SCALE;
        3: return -spls_pkg::FULL_SCALE;
        default: return 0;
      endcase
    end
    mag = $urandom_range(0, spls_pkg::FULL_SCALE);
    if (r < 6) begin
      // Land exactly on a breakpoint when the picked slot has been written
      slot = $urandom_range(0, spls_pkg::MAX_POINTS - 1);
      if (slot_written[slot]) begin
        mag = bp_in[slot];
      end
    end
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic test_empty_table();
    apply_force(0);
    apply_force(32767);
    apply_force(-32768);
    apply_force(spls_pkg::FULL_SCALE + 1);
    apply_force(-1);
  endtask

  task automatic test_flat_and_saturating_table();
    // One point only: still passthrough
    write_point(0, 16383, 16383, 1'b1);
    apply_force(-2500);
    // Flat interval first, then a steep one that overshoots full scale
    write_point(0, 3000, 7000, 1'b0);
    write_point(1, 3000, 500, 1'b0);
    write_point(2, spls_pkg::FULL_SCALE, 16383, 1'b0);
    write_point(3, 16383, 0, 1'b1);
    apply_force(3000);
    apply_force(-3000);
    apply_force(100);
    apply_force(6500);
    apply_force(spls_pkg::FULL_SCALE);
    apply_force(-32768);
    apply_force(12000);
  endtask

  task automatic test_drain_pause();
    quiet = 1'b0;
    repeat (6) apply_force(pick_force());
    wait_drained();
    repeat (4) apply_force(pick_force());
    wait_drained();
  endtask

  task automatic load_sorted_table();
    int n, x, span;
    bit reach_top;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, spls_pkg::MAX_POINTS)
                                    : $urandom_range(2, 6);
    x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4000) : 0;
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, spls_pkg::FULL_SCALE)
                                       : spls_pkg::FULL_SCALE;
    reach_top = $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      write_point(k, x, pick_level(), k == n - 1);
      x = x + $urandom_range(0, 2 * span / n);
      if (k == n - 2 && reach_top) begin
        x = spls_pkg::FULL_SCALE;
      end
      if (x > spls_pkg::FULL_SCALE) begin
        x = spls_pkg::FULL_SCALE;
      end
    end
  endtask

  task automatic test_random_tables();
    int n;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            write_point($urandom_range(0, spls_pkg::MAX_POINTS - 1), $urandom_range(0, 16383),
                        $urandom_range(0, 16383), 1'($urandom_range(0, 1)));
          end
        end
        1: begin
          n = $urandom_range(1, spls_pkg::MAX_POINTS);
          for (int k = 0; k < n; k++) begin
            write_point(k, $urandom_range(0, 16383), $urandom_range(0, 16383), k == n - 1);
          end
        end
        default: load_sorted_table();
      endcase
      repeat ($urandom_range(4, 12)) apply_force(pick_force());
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
  endtask

  // Output side: random stalls
  initial begin : ready_driver
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    shaped_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_shapes.size() == 0) begin
        note_failure($sformatf("result %0d/%0b with nothing pending",
                               $signed(m_axis_tdata[spls_pkg::OUT_W-1:0]), m_axis_tuser));
      end else begin
        want = pending_shapes.pop_front();
        if (m_axis_tdata[spls_pkg::OUT_W-1:0] !== want.shaped) begin
          note_failure($sformatf("shaped_force expected %0d got %0d",
                                 $signed(want.shaped),
                                 $signed(m_axis_tdata[spls_pkg::OUT_W-1:0])));
        end
        if (m_axis_tuser !== want.used) begin
          note_failure($sformatf("table_used expected %0b got %0b", want.used, m_axis_tuser));
        end
        if (m_axis_tdata[spls_pkg::OUT_DATA_W-1:spls_pkg::OUT_W] !== '0) begin
          note_failure($sformatf("tdata pad expected 0 got %0b",
                                 m_axis_tdata[spls_pkg::OUT_DATA_W-1:spls_pkg::OUT_W]));
        end
      end
    end
  end

  initial begin
    fail_count    = 0;
    items_sent    = 0;
    point_count   = 0;
    slot_written  = '0;
    quiet         = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= MODE_APPLY;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_flat_and_saturating_table();
    test_drain_pause();
    test_random_tables();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/spls_pkg.sv
src/spls_table.sv
src/spls_muldiv.sv
src/symmetric_piecewise_linear_shaper.sv
tb/testbench.sv
